[rtl/albe_pkg.sv]
// albe_pkg.sv: shared types, constants and codes of the line blend engine
package albe_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int CW      = 12;   // signed walk coordinate
    localparam int EW      = 16;   // signed walk error
    localparam int DIV_NW  = 32;   // divider dividend / quotient width
    localparam int DIV_DW  = 16;   // divider divisor width
    localparam int QDEPTH  = 2;    // command queue entries

    localparam logic [1:0] MODE_PLACE = 2'd0;
    localparam logic [1:0] MODE_LINE  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] IMG_SIZE_RESET = 8'd128;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] start_x;
        logic [6:0] start_y;
        logic [6:0] end_x;
        logic [6:0] end_y;
        logic [9:0] line_width;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
        logic [15:0] pixels_written;
        logic        in_range;
    } t_out_item;

    typedef enum logic [1:0] {
        K_PLACE,
        K_LINE,
        K_READ,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  x0;
        logic [6:0]  y0;
        logic [6:0]  x1;
        logic [6:0]  y1;
        logic [6:0]  dx;
        logic [6:0]  dy;
        logic        sx;     // 1: step +1
        logic        sy;
        logic [13:0] t8;     // half width plus one half, Q.8
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_cmd;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ITER,
        S_LIM,
        S_L_TOP,
        S_L_A,
        S_L_LOOP1,
        S_L_B,
        S_L_LOOP2,
        S_P_LOC,
        S_P_ADDR,
        S_P_WAIT,
        S_P_FDIV,
        S_P_FADE,
        S_B_MUL,
        S_B_OA,
        S_B_CH_MUL,
        S_B_CH_GO,
        S_B_CH_WAIT,
        S_P_WRITE,
        S_DONE
    } t_state;

endpackage

[rtl/antialiased_line_blend_engine_unit.sv]
// antialiased_line_blend_engine_unit.sv: top level of the line blend engine
// An RGBA frame store of MAX_WIDTH*MAX_HEIGHT words with three request types:
// read pixel, place pixel (alpha "over" blend) and draw an anti-aliased thick
// line, each request giving exactly one result. After reset the store is
// cleared one word a cycle, all MAX_WIDTH*MAX_HEIGHT words (16384 by default),
// during which o_in_stall stays high. A two-entry queue sits between intake
// and the sequencer, and a result register lets the next request enter while
// a result waits. Requests run one at a time: a read uses no divide, a place
// uses the shared one-bit-per-cycle divider (three channel divides per blend,
// none when the output alpha is zero; the output alpha's divide by 255 is a
// shift and add). A line first takes the distance square root, then a fade
// divide and the channel divides for each blended pixel, while an off-image
// pixel is skipped without a divide. Configuration writes are always ready
// and should only be issued while the engine is idle.
module antialiased_line_blend_engine_unit
    import albe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_img_w, r_img_h;
    logic [7:0] w_img_w, w_img_h;
    t_cmd       w_cmd;
    logic       w_q_valid;
    logic       w_pop;
    logic       w_clearing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_SIZE_RESET;
            r_img_h <= IMG_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // active size never exceeds the store
    assign w_img_w = (r_img_w > MAX_WIDTH)  ? 8'(MAX_WIDTH)  : r_img_w;
    assign w_img_h = (r_img_h > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : r_img_h;

    albe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_clearing (w_clearing),
        .o_cmd      (w_cmd),
        .o_cmd_valid(w_q_valid),
        .i_cmd_pop  (w_pop)
    );

    albe_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cmd_valid(w_q_valid),
        .o_cmd_pop  (w_pop),
        .i_img_w    (w_img_w),
        .i_img_h    (w_img_h),
        .o_clearing (w_clearing),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    a_clear_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_in_stall)
        else $error("request accepted during store clear");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("command queue popped while empty");

    a_count_implies_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.pixels_written != 16'h0000)) |-> o_out_item.in_range)
        else $error("pixels written without in_range");

endmodule

[rtl/albe_ram.sv]
// albe_ram.sv: generic single-write, single-read RAM with registered read
module albe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/albe_div.sv]
// albe_div.sv: restoring divider, one quotient bit per cycle
module albe_div
    import albe_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    localparam int CNW = $clog2(NW + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [NW-1:0]  r_quo, n_quo;
    logic [DW-1:0]  r_rem, n_rem;
    logic [DW-1:0]  r_dvs, n_dvs;
    logic [DW:0]    w_trial;
    logic [DW:0]    w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNW'(NW);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[NW-2:0], w_ge};
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_cnt = r_cnt - CNW'(1);
            if (r_cnt == CNW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/albe_front.sv]
// albe_front.sv: request intake, mode decode, line setup and command queue
module albe_front
    import albe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    input  logic     i_clearing,
    output t_cmd     o_cmd,
    output logic     o_cmd_valid,
    input  logic     i_cmd_pop
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_cmd           r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    t_cmd           w_cmd;
    logic           w_push;
    logic           w_full;

    assign w_full      = (r_cnt == QCW'(QDEPTH));
    assign o_in_stall  = w_full || i_clearing;
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        w_cmd       = '0;
        case (i_in_item.mode)
            MODE_PLACE: w_cmd.kind = K_PLACE;
            MODE_LINE:  w_cmd.kind = K_LINE;
            MODE_READ:  w_cmd.kind = K_READ;
            default:    w_cmd.kind = K_NONE;
        endcase
        w_cmd.x0    = i_in_item.start_x;
        w_cmd.y0    = i_in_item.start_y;
        w_cmd.x1    = i_in_item.end_x;
        w_cmd.y1    = i_in_item.end_y;
        w_cmd.dx    = (i_in_item.end_x > i_in_item.start_x) ?
                      i_in_item.end_x - i_in_item.start_x :
                      i_in_item.start_x - i_in_item.end_x;
        w_cmd.dy    = (i_in_item.end_y > i_in_item.start_y) ?
                      i_in_item.end_y - i_in_item.start_y :
                      i_in_item.start_y - i_in_item.end_y;
        w_cmd.sx    = (i_in_item.start_x < i_in_item.end_x);
        w_cmd.sy    = (i_in_item.start_y < i_in_item.end_y);
        w_cmd.t8    = {({1'b0, i_in_item.line_width} + 11'd16), 3'b000};
        w_cmd.red   = i_in_item.red;
        w_cmd.green = i_in_item.green;
        w_cmd.blue  = i_in_item.blue;
        w_cmd.alpha = i_in_item.alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (i_cmd_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            if (w_push && !i_cmd_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (!w_push && i_cmd_pop) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

[rtl/albe_back.sv]
// albe_back.sv: command sequencer: store clear, pixel read, line walk, fade and blend
module albe_back
    import albe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_valid,
    output logic      o_cmd_pop,
    input  logic [7:0] i_img_w,
    input  logic [7:0] i_img_h,
    output logic      o_clearing,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_cmd   r_cmd, n_cmd;
    logic [AW:0] r_clr, n_clr;

    logic signed [CW-1:0] r_x0, n_x0, r_y0, n_y0, r_x2, n_x2, r_y2, n_y2;
    logic signed [CW-1:0] r_px, n_px, r_py, n_py;
    logic signed [EW-1:0] r_err, n_err, r_e2, n_e2, r_pe, n_pe;
    logic [31:0] r_n, n_n, r_root, n_root, r_bit, n_bit;
    logic [15:0] r_ed8, n_ed8;
    logic [31:0] r_lim, n_lim;
    logic [7:0]  r_row, n_row;
    logic [AW-1:0] r_addr, n_addr;
    logic [7:0]  r_alpha, n_alpha;
    logic [15:0] r_a, n_a, r_keep, n_keep, r_m1, n_m1;
    logic [23:0] r_m2, n_m2;
    logic [7:0]  r_oa, n_oa, r_rr, n_rr, r_rg, n_rg, r_rb, n_rb;
    logic [1:0]  r_ch, n_ch;
    logic [31:0] r_last, n_last;
    logic [15:0] r_count, n_count;
    logic        r_hit, n_hit;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item, n_out_item;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata, ram_rdata;
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_dividend, div_quo;
    logic [DIV_DW-1:0] div_divisor;

    // decoded conditions
    logic signed [CW-1:0]  w_x1, w_y1, w_ws, w_hs;
    logic signed [EW:0]    w_dx17, w_dy17, w_err2, w_e2x2;
    logic signed [EW+16:0] w_e2sh, w_lims;
    logic signed [EW-1:0]  w_dxe, w_dye;
    logic        c_lim, c_loop1, c_loop2, c_a, c_b, c_inside, c_out_free;
    logic [EW-1:0] w_pmag;
    logic signed [DIV_NW+1:0] w_v;
    logic [23:0] w_v255;
    logic [7:0]  w_fade;
    logic [31:0] w_word;
    logic [31:0] w_sq_try;
    logic [16:0] w_oa_sum;

    assign w_x1   = {{(CW-7){1'b0}}, r_cmd.x1};
    assign w_y1   = {{(CW-7){1'b0}}, r_cmd.y1};
    assign w_ws   = {{(CW-8){1'b0}}, i_img_w};
    assign w_hs   = {{(CW-8){1'b0}}, i_img_h};
    assign w_dxe  = {{(EW-7){1'b0}}, r_cmd.dx};
    assign w_dye  = {{(EW-7){1'b0}}, r_cmd.dy};
    assign w_dx17 = {{(EW+1-7){1'b0}}, r_cmd.dx};
    assign w_dy17 = {{(EW+1-7){1'b0}}, r_cmd.dy};
    assign w_err2 = {r_err, 1'b0};
    assign w_e2x2 = {r_e2, 1'b0};
    assign w_e2sh = {r_e2[EW-1], r_e2, 16'h0000};
    assign w_lims = {{(EW+17-32){1'b0}}, r_lim};

    assign c_lim    = (w_e2sh < w_lims);
    assign c_loop1  = c_lim && ((w_y1 != r_y2) || (r_cmd.dx > r_cmd.dy));
    assign c_loop2  = c_lim && ((w_x1 != r_x2) || (r_cmd.dx < r_cmd.dy));
    assign c_a      = (w_err2 >= -w_dx17);
    assign c_b      = (w_e2x2 <= w_dy17);
    assign c_inside = (r_px >= 0) && (r_py >= 0) && (r_px < w_ws) && (r_py < w_hs);
    assign c_out_free = !r_out_valid || !i_out_stall;

    // fade: V = floor(|e|*65536/ED) - T + 256, scaled by 255/256, low byte
    assign w_pmag = (r_pe < 0) ? -r_pe : r_pe;
    assign w_v    = $signed({2'b00, div_quo}) - $signed({{(DIV_NW+2-14){1'b0}}, r_cmd.t8})
                    + $signed((DIV_NW+2)'(256));
    assign w_v255 = {w_v[15:0], 8'h00} - {8'h00, w_v[15:0]};
    assign w_fade = (w_v <= 0) ? 8'h00 : w_v255[15:8];

    // floor(a/255) for any 16-bit a below 65535: (a + 1 + (a >> 8)) >> 8
    assign w_oa_sum = {1'b0, r_a} + 17'd1 + {9'h000, r_a[15:8]};

    assign w_word   = {r_oa, r_rb, r_rg, r_rr};
    assign w_sq_try = r_root + r_bit;

    assign ram_waddr = (r_state == S_CLEAR) ? r_clr[AW-1:0] : r_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? 32'h0 : w_word;

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    albe_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    albe_div #(
        .NW(DIV_NW),
        .DW(DIV_DW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:     if (r_clr == (AW+1)'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_LINE:  n_state = S_SQ_MUL;
                        K_PLACE: n_state = S_P_LOC;
                        K_READ:  n_state = S_P_LOC;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SQ_MUL:    n_state = S_SQ_ITER;
            S_SQ_ITER:   if (r_bit == 32'd1) n_state = S_LIM;
            S_LIM:       n_state = S_L_TOP;
            S_L_TOP:     n_state = S_P_LOC;
            S_L_A:       n_state = c_a ? S_L_LOOP1 : S_L_B;
            S_L_LOOP1: begin
                if (c_loop1) n_state = S_P_LOC;
                else if (r_x0 == w_x1) n_state = S_DONE;
                else n_state = S_L_B;
            end
            S_L_B:       n_state = c_b ? S_L_LOOP2 : S_L_TOP;
            S_L_LOOP2: begin
                if (c_loop2) n_state = S_P_LOC;
                else if (r_y0 == w_y1) n_state = S_DONE;
                else n_state = S_L_TOP;
            end
            S_P_LOC:     n_state = c_inside ? S_P_ADDR : r_ret;
            S_P_ADDR:    n_state = S_P_WAIT;
            S_P_WAIT:    n_state = (r_cmd.kind == K_LINE) ? S_P_FDIV : S_P_FADE;
            S_P_FDIV:    if (div_done) n_state = S_P_FADE;
            S_P_FADE:    n_state = (r_cmd.kind == K_READ) ? r_ret : S_B_MUL;
            S_B_MUL:     n_state = S_B_OA;
            S_B_OA:      n_state = (r_a == 16'h0) ? S_P_WRITE : S_B_CH_MUL;
            S_B_CH_MUL:  n_state = S_B_CH_GO;
            S_B_CH_GO:   n_state = S_B_CH_WAIT;
            S_B_CH_WAIT: begin
                if (div_done) n_state = (r_ch == 2'd2) ? S_P_WRITE : S_B_CH_MUL;
            end
            S_P_WRITE:   n_state = r_ret;
            S_DONE:      if (c_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        logic [7:0]  fc, bc;
        logic [15:0] ed;
        n_ret = r_ret;     n_cmd = r_cmd;     n_clr = r_clr;
        n_x0 = r_x0;       n_y0 = r_y0;       n_x2 = r_x2;     n_y2 = r_y2;
        n_px = r_px;       n_py = r_py;       n_pe = r_pe;
        n_err = r_err;     n_e2 = r_e2;
        n_n = r_n;         n_root = r_root;   n_bit = r_bit;
        n_ed8 = r_ed8;     n_lim = r_lim;     n_row = r_row;   n_addr = r_addr;
        n_alpha = r_alpha; n_a = r_a;         n_keep = r_keep;
        n_m1 = r_m1;       n_m2 = r_m2;       n_oa = r_oa;     n_ch = r_ch;
        n_rr = r_rr;       n_rg = r_rg;       n_rb = r_rb;
        n_last = r_last;   n_count = r_count; n_hit = r_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        ram_we       = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_NW'({w_pmag, 16'h0000});
        div_divisor  = r_ed8;
        fc = r_cmd.red;
        bc = ram_rdata[7:0];
        ed = (r_cmd.dx == 7'd0 && r_cmd.dy == 7'd0) ? 16'd256 : r_root[15:0];
        case (r_ch)
            2'd1:    begin fc = r_cmd.green; bc = ram_rdata[15:8];  end
            2'd2:    begin fc = r_cmd.blue;  bc = ram_rdata[23:16]; end
            default: begin fc = r_cmd.red;   bc = ram_rdata[7:0];   end
        endcase
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + (AW+1)'(1);
            end
            S_IDLE: begin
                n_cmd   = i_cmd;
                n_count = 16'h0;
                n_hit   = 1'b0;
                n_last  = 32'h0;
                n_x0    = {{(CW-7){1'b0}}, i_cmd.x0};
                n_y0    = {{(CW-7){1'b0}}, i_cmd.y0};
                n_px    = {{(CW-7){1'b0}}, i_cmd.x0};
                n_py    = {{(CW-7){1'b0}}, i_cmd.y0};
                n_err   = {{(EW-7){1'b0}}, i_cmd.dx} - {{(EW-7){1'b0}}, i_cmd.dy};
                n_ret   = S_DONE;
            end
            S_SQ_MUL: begin
                n_n    = {1'b0, ({8'h00, r_cmd.dx} * {8'h00, r_cmd.dx})
                               + ({8'h00, r_cmd.dy} * {8'h00, r_cmd.dy}), 16'h0000};
                n_root = 32'h0;
                n_bit  = 32'h4000_0000;
            end
            S_SQ_ITER: begin
                if (r_n >= w_sq_try) begin
                    n_n    = r_n - w_sq_try;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
            end
            S_LIM: begin
                n_ed8 = ed;
                n_lim = {16'h0000, ed} * {18'h00000, r_cmd.t8};
            end
            S_L_TOP: begin
                n_px  = r_x0;
                n_py  = r_y0;
                n_pe  = r_err - w_dxe + w_dye;
                n_ret = S_L_A;
            end
            S_L_A: begin
                n_e2 = r_err;
                n_x2 = r_x0;
                if (c_a) begin
                    n_e2 = r_err + w_dye;
                    n_y2 = r_y0;
                end
            end
            S_L_LOOP1: begin
                if (c_loop1) begin
                    n_y2  = r_cmd.sy ? r_y2 + CW'(1) : r_y2 - CW'(1);
                    n_px  = r_x0;
                    n_py  = r_cmd.sy ? r_y2 + CW'(1) : r_y2 - CW'(1);
                    n_pe  = r_e2;
                    n_e2  = r_e2 + w_dxe;
                    n_ret = S_L_LOOP1;
                end else if (r_x0 != w_x1) begin
                    n_e2  = r_err;
                    n_err = r_err - w_dye;
                    n_x0  = r_cmd.sx ? r_x0 + CW'(1) : r_x0 - CW'(1);
                end
            end
            S_L_B: begin
                if (c_b) n_e2 = w_dxe - r_e2;
            end
            S_L_LOOP2: begin
                if (c_loop2) begin
                    n_x2  = r_cmd.sx ? r_x2 + CW'(1) : r_x2 - CW'(1);
                    n_px  = r_cmd.sx ? r_x2 + CW'(1) : r_x2 - CW'(1);
                    n_py  = r_y0;
                    n_pe  = r_e2;
                    n_e2  = r_e2 + w_dye;
                    n_ret = S_L_LOOP2;
                end else if (r_y0 != w_y1) begin
                    n_err = r_err + w_dxe;
                    n_y0  = r_cmd.sy ? r_y0 + CW'(1) : r_y0 - CW'(1);
                end
            end
            S_P_LOC: begin
                n_row = 8'(w_hs - CW'(1) - r_py);
            end
            S_P_ADDR: begin
                n_addr = AW'({8'h00, i_img_w} * {8'h00, r_row} + {8'h00, r_px[7:0]});
            end
            S_P_WAIT: begin
                if (r_cmd.kind == K_LINE) div_start = 1'b1;
            end
            S_P_FADE: begin
                if (r_cmd.kind == K_READ) begin
                    n_last = ram_rdata;
                    n_hit  = 1'b1;
                end else if (r_cmd.kind == K_LINE) begin
                    n_alpha = r_cmd.alpha - w_fade;
                end else begin
                    n_alpha = r_cmd.alpha;
                end
            end
            S_B_MUL: begin
                n_a    = 16'd65025 - ((8'd255 - r_alpha) * (8'd255 - ram_rdata[31:24]));
                n_keep = ram_rdata[31:24] * (8'd255 - r_alpha);
            end
            S_B_OA: begin
                if (r_a == 16'h0) begin
                    n_oa = 8'h00;
                    n_rr = 8'h00;
                    n_rg = 8'h00;
                    n_rb = 8'h00;
                end else begin
                    n_oa = w_oa_sum[15:8];
                    n_ch = 2'd0;
                end
            end
            S_B_CH_MUL: begin
                n_m1 = fc * r_alpha;
                n_m2 = bc * r_keep;
            end
            S_B_CH_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_NW'({r_m1, 8'h00}) - DIV_NW'(r_m1) + DIV_NW'(r_m2);
                div_divisor  = r_a;
            end
            S_B_CH_WAIT: begin
                if (div_done) begin
                    case (r_ch)
                        2'd0:    n_rr = div_quo[7:0];
                        2'd1:    n_rg = div_quo[7:0];
                        default: n_rb = div_quo[7:0];
                    endcase
                    n_ch = r_ch + 2'd1;
                end
            end
            S_P_WRITE: begin
                ram_we = 1'b1;
                n_last = w_word;
                n_hit  = 1'b1;
                if (r_count != 16'hFFFF) n_count = r_count + 16'd1;
            end
            S_DONE: begin
                if (c_out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_item.out_red         = r_last[7:0];
                    n_out_item.out_green       = r_last[15:8];
                    n_out_item.out_blue        = r_last[23:16];
                    n_out_item.out_alpha       = r_last[31:24];
                    n_out_item.pixels_written  = r_count;
                    n_out_item.in_range        = r_hit;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_ret <= n_ret;     r_cmd <= n_cmd;
        r_x0 <= n_x0;       r_y0 <= n_y0;     r_x2 <= n_x2;    r_y2 <= n_y2;
        r_px <= n_px;       r_py <= n_py;     r_pe <= n_pe;
        r_err <= n_err;     r_e2 <= n_e2;
        r_n <= n_n;         r_root <= n_root; r_bit <= n_bit;
        r_ed8 <= n_ed8;     r_lim <= n_lim;   r_row <= n_row;  r_addr <= n_addr;
        r_alpha <= n_alpha; r_a <= n_a;       r_keep <= n_keep;
        r_m1 <= n_m1;       r_m2 <= n_m2;     r_oa <= n_oa;    r_ch <= n_ch;
        r_rr <= n_rr;       r_rg <= n_rg;     r_rb <= n_rb;
        r_last <= n_last;   r_count <= n_count; r_hit <= n_hit;
        r_out_item <= n_out_item;
    end

endmodule
